FILE: design/tdm_pkg.sv
// Shared types, codes and helpers of the task deadline monitor.
package tdm_pkg;

  localparam int TIME_W     = 32;
  localparam int CNT_W      = 16;
  localparam int PERIOD_W   = 24;
  localparam int OFFSET_W   = 24;
  localparam int REQ_W      = 2;
  localparam int TASK_W     = 3;
  localparam int STATUS_W   = 2;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int NUM_TASKS_DEF = 5;

  localparam logic [TIME_W-1:0]   TEST_LENGTH_RST = 32'd10000000;
  localparam logic [PERIOD_W-1:0] PERIOD_RST      = 24'd1000;

  localparam logic [REQ_W-1:0] REQ_START = 2'd0;
  localparam logic [REQ_W-1:0] REQ_BEGIN = 2'd1;
  localparam logic [REQ_W-1:0] REQ_END   = 2'd2;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd3;

  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_IDLE     = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVER     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_BAD_TASK = 2'd3;

  localparam int REG_START_OFFSET = 0;
  localparam int REG_TEST_LENGTH  = 1;
  localparam int REG_PERIOD_BASE  = 2;

  typedef struct packed {
    logic [OFFSET_W-1:0] start_offset;
    logic [TIME_W-1:0]   test_length;
  } cfg_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic                violation_now;
    logic [CNT_W-1:0]    violations;
    logic [CNT_W-1:0]    jobs_done;
    logic [TIME_W-1:0]   first_begin;
    logic [TIME_W-1:0]   first_end;
    logic [TIME_W-1:0]   start_time;
  } res_t;

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
  endfunction

endpackage

FILE: design/tdm_cfg_regs.sv
// Configuration register file: start offset, test length and task periods.
module tdm_cfg_regs import tdm_pkg::*; #(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg,
  output logic [PERIOD_W-1:0]   period [NUM_TASKS]
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.start_offset <= '0;
      cfg.test_length  <= TEST_LENGTH_RST;
      for (int i = 0; i < NUM_TASKS; i++) begin
        period[i] <= PERIOD_RST;
      end
    end else if (cfg_we) begin
      if (cfg_index == CFG_IDX_W'(REG_START_OFFSET)) begin
        cfg.start_offset <= cfg_data[OFFSET_W-1:0];
      end
      if (cfg_index == CFG_IDX_W'(REG_TEST_LENGTH)) begin
        cfg.test_length <= cfg_data[TIME_W-1:0];
      end
      for (int i = 0; i < NUM_TASKS; i++) begin
        if (cfg_index == CFG_IDX_W'(REG_PERIOD_BASE + i)) begin
          period[i] <= cfg_data[PERIOD_W-1:0];
        end
      end
    end
  end

endmodule

FILE: design/tdm_core.sv
// Monitor state per task and the single-pass update for one request.
module tdm_core import tdm_pkg::*; #(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic [REQ_W-1:0]    req,
  input  logic [TASK_W-1:0]   task_num,
  input  logic [TIME_W-1:0]   now,
  input  cfg_t                cfg,
  input  logic [PERIOD_W-1:0] period [NUM_TASKS],
  output res_t                res
);

  localparam int IDX_W = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;

  logic              active;
  logic [TIME_W-1:0] start_time_reg;
  logic [TIME_W-1:0] release_time     [NUM_TASKS];
  logic [TIME_W-1:0] next_deadline    [NUM_TASKS];
  logic [TIME_W-1:0] first_begin_time [NUM_TASKS];
  logic [TIME_W-1:0] first_end_time   [NUM_TASKS];
  logic [CNT_W-1:0]  job_count        [NUM_TASKS];
  logic [CNT_W-1:0]  violation_count  [NUM_TASKS];

  logic [IDX_W-1:0]  tidx;
  logic              good_task;
  logic              is_start;
  logic              is_job;
  logic              over;
  logic              count;
  logic              vio;
  logic              wr_task;
  logic [TIME_W-1:0] start_time_next;
  logic [TIME_W-1:0] rel_cur;
  logic [TIME_W-1:0] dl_cur;
  logic [TIME_W-1:0] fb_cur;
  logic [TIME_W-1:0] fe_cur;
  logic [CNT_W-1:0]  jc_cur;
  logic [CNT_W-1:0]  vc_cur;
  logic [TIME_W-1:0] rel_next;
  logic [TIME_W-1:0] dl_next;
  logic [TIME_W-1:0] fb_next;
  logic [TIME_W-1:0] fe_next;
  logic [CNT_W-1:0]  jc_next;
  logic [CNT_W-1:0]  vc_next;
  logic              active_next;

  assign tidx      = IDX_W'(task_num - 3'd1);
  assign good_task = (task_num != '0) && (task_num <= TASK_W'(NUM_TASKS));
  assign is_start  = (req == REQ_START);
  assign is_job    = (req == REQ_BEGIN) || (req == REQ_END);

  assign rel_cur = release_time[tidx];
  assign dl_cur  = next_deadline[tidx];
  assign fb_cur  = first_begin_time[tidx];
  assign fe_cur  = first_end_time[tidx];
  assign jc_cur  = job_count[tidx];
  assign vc_cur  = violation_count[tidx];

  assign start_time_next = now + {{(TIME_W-OFFSET_W){1'b0}}, cfg.start_offset};
  assign over            = (now - start_time_reg) > cfg.test_length;
  assign count           = is_job && !over;
  assign vio = count && (((req == REQ_BEGIN) && (now < rel_cur)) ||
                         ((req == REQ_END) && (now > dl_cur)));

  assign fb_next  = ((req == REQ_BEGIN) && (fb_cur == '0)) ? now : fb_cur;
  assign fe_next  = ((req == REQ_END) && (fe_cur == '0)) ? now : fe_cur;
  assign vc_next  = vio ? sat_inc(vc_cur) : vc_cur;
  assign jc_next  = (count && (req == REQ_END)) ? sat_inc(jc_cur) : jc_cur;
  assign rel_next = (count && (req == REQ_END)) ? dl_cur : rel_cur;
  assign dl_next  = (count && (req == REQ_END)) ?
                    dl_cur + {{(TIME_W-PERIOD_W){1'b0}}, period[tidx]} : dl_cur;

  assign wr_task     = in_valid && is_job && active && good_task;
  assign active_next = (in_valid && is_start) ? 1'b1 :
                       (wr_task && over)      ? 1'b0 : active;

  always_comb begin
    res = '0;
    res.start_time = start_time_reg;
    if (is_start) begin
      res.status     = ST_OK;
      res.start_time = start_time_next;
    end else if (is_job && !active) begin
      res.status = ST_IDLE;
    end else if (!good_task) begin
      res.status = ST_BAD_TASK;
    end else begin
      res.status        = (is_job && over) ? ST_OVER : ST_OK;
      res.violation_now = vio;
      res.violations    = vc_next;
      res.jobs_done     = jc_next;
      res.first_begin   = fb_next;
      res.first_end     = fe_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      start_time_reg <= '0;
      for (int i = 0; i < NUM_TASKS; i++) begin
        release_time[i]     <= '0;
        next_deadline[i]    <= '0;
        first_begin_time[i] <= '0;
        first_end_time[i]   <= '0;
        job_count[i]        <= '0;
        violation_count[i]  <= '0;
      end
    end else begin
      active <= active_next;
      if (in_valid && is_start) begin
        start_time_reg <= start_time_next;
        for (int i = 0; i < NUM_TASKS; i++) begin
          release_time[i]     <= start_time_next;
          next_deadline[i]    <= start_time_next + {{(TIME_W-PERIOD_W){1'b0}}, period[i]};
          first_begin_time[i] <= '0;
          first_end_time[i]   <= '0;
          job_count[i]        <= '0;
          violation_count[i]  <= '0;
        end
      end else if (wr_task) begin
        release_time[tidx]     <= rel_next;
        next_deadline[tidx]    <= dl_next;
        first_begin_time[tidx] <= fb_next;
        first_end_time[tidx]   <= fe_next;
        job_count[tidx]        <= jc_next;
        violation_count[tidx]  <= vc_next;
      end
    end
  end

endmodule

FILE: design/task_deadline_monitor.sv
// Top level of the task deadline monitor.
//
// Request channel: drive req_type, task_number and now with start high; a
// request is taken at each rising edge where start is high and busy is low.
// busy is high only while rst is asserted, so one request per cycle is taken.
// Result channel: once a request is taken, done is high for one cycle with
// status, violation_now, the task's counters, first begin/end times and
// start_time. Results cannot be held off; each lasts one cycle. A request
// goes through the input register, then one pass of compare/add logic into
// the result register; throughput is 1 request per cycle.
// Configuration: cfg_we writes cfg_data to register cfg_index (0 start
// offset, 1 test length, 2 and up task periods) at the clock edge; write
// only while no request is in flight.
// Reset: synchronous; clears all task records, stops monitoring and loads
// default test length and periods. No result is produced for reset.
module task_deadline_monitor import tdm_pkg::*; #(
  parameter int NUM_TASKS = NUM_TASKS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  output logic                  busy,
  input  logic [REQ_W-1:0]      req_type,
  input  logic [TASK_W-1:0]     task_number,
  input  logic [TIME_W-1:0]     now,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output logic                  done,
  output logic [STATUS_W-1:0]   status,
  output logic                  violation_now,
  output logic [CNT_W-1:0]      violations,
  output logic [CNT_W-1:0]      jobs_done,
  output logic [TIME_W-1:0]     first_begin,
  output logic [TIME_W-1:0]     first_end,
  output logic [TIME_W-1:0]     start_time
);

  logic                in_valid;
  logic [REQ_W-1:0]    req_q;
  logic [TASK_W-1:0]   task_q;
  logic [TIME_W-1:0]   now_q;
  cfg_t                cfg;
  logic [PERIOD_W-1:0] period [NUM_TASKS];
  res_t                res;
  res_t                res_q;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      done     <= 1'b0;
    end else begin
      in_valid <= start;
      done     <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      req_q  <= req_type;
      task_q <= task_number;
      now_q  <= now;
    end
    if (in_valid) begin
      res_q <= res;
    end
  end

  tdm_cfg_regs #(
    .NUM_TASKS(NUM_TASKS)
  ) u_cfg (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .cfg      (cfg),
    .period   (period)
  );

  tdm_core #(
    .NUM_TASKS(NUM_TASKS)
  ) u_core (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .req     (req_q),
    .task_num(task_q),
    .now     (now_q),
    .cfg     (cfg),
    .period  (period),
    .res     (res)
  );

  assign status        = res_q.status;
  assign violation_now = res_q.violation_now;
  assign violations    = res_q.violations;
  assign jobs_done     = res_q.jobs_done;
  assign first_begin   = res_q.first_begin;
  assign first_end     = res_q.first_end;
  assign start_time    = res_q.start_time;

`ifndef SYNTHESIS
  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    start |=> ##1 done)
    else $error("beat taken without a result two cycles later");

  a_over_no_vio: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_OVER) |-> !violation_now)
    else $error("violation flagged on the beat that ended the test");

  a_reject_empty: assert property (@(posedge clk) disable iff (rst)
    (done && (status == ST_IDLE || status == ST_BAD_TASK)) |->
      (violations == '0 && jobs_done == '0 && !violation_now))
    else $error("rejected beat carries task records");

  a_vio_counted: assert property (@(posedge clk) disable iff (rst)
    (done && violation_now) |-> (violations != '0))
    else $error("violation flagged but count is zero");
`endif

endmodule
